// ===== design/gsm_pkg.sv =====
`default_nettype none
package gsm_pkg;
    localparam int MAX_MAP_CELLS = 65536;
    localparam int MAX_POINTS = 1024;
    localparam int MAP_AW = $clog2(MAX_MAP_CELLS);
    localparam int PT_AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam int TW = 50;
    localparam int QW = 29;
    localparam int HW = 41;
    localparam int MA_W = 34;
    localparam int MB_W = 18;
    localparam int MP_W = 52;
    localparam int LO_W = 25;
    localparam int Q_SH = 13;

    localparam logic [17:0] SCORE_MAX = 18'h3FFFF;
    localparam logic [10:0] INSIDE_MAX = 11'h7FF;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_POINT = 2'd1,
        OP_SCORE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_MAP_WIDTH  = 3'd0,
        REG_MAP_HEIGHT = 3'd1,
        REG_NUM_POINTS = 3'd2,
        REG_ORIGIN_X   = 3'd3,
        REG_ORIGIN_Y   = 3'd4,
        REG_CPM        = 3'd5,
        REG_SENSOR_X   = 3'd6,
        REG_SENSOR_Y   = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OFF,
        S_PT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               map_wr;
        logic [MAP_AW-1:0]  map_wr_addr;
        logic [7:0]         map_wr_data;
        logic               map_rd;
        logic [MAP_AW-1:0]  map_rd_addr;
        logic               pt_wr;
        logic [PT_AW-1:0]   pt_wr_addr;
        logic [31:0]        pt_wr_x;
        logic [31:0]        pt_wr_y;
        logic               pt_rd;
        logic [PT_AW-1:0]   pt_rd_addr;
    } t_store_req;
endpackage
`default_nettype wire

// ===== design/grid_scan_match_pose_score_top.sv =====
// Pose scorer for 2-D correlative scan matching against an 8-bit occupancy map.
// Input channel (i_valid / o_stall) carries one word per operation:
//   map write   - stores i_cell_value at i_address.
//   point write - stores (i_point_x, i_point_y) at i_address below 1024.
//   score pose  - rotates and shifts the first num_points points (at most 1024), sums map values at hits.
// Output channel (o_valid / i_stall) carries score and points_inside, one word
// per score query only.
// A query runs setup steps for the sensor offset, then a run of steps per point,
// then a hand-off. Its length is set by the single shared 34x18 multiplier,
// which forms 9 products per point, and by the map read port.
// The block accepts nothing while a query runs (o_stall high); map and point
// writes are taken back to back when idle.
// A finished result sits in an output register; the next query may be taken
// while it waits. If the receiver still stalls when the next query finishes,
// the block holds in its done state until the register frees.
// Configuration is an APB slave; write registers only while idle.
// Reset (synchronous, active low) restores register defaults and drops o_valid;
// map and point stores are not cleared.
`default_nettype none
module grid_scan_match_pose_score_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [1:0]     i_operation,
    input  wire logic [15:0]    i_address,
    input  wire logic [7:0]     i_cell_value,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_pose_x,
    input  wire logic signed [31:0] i_pose_y,
    input  wire logic signed [15:0] i_yaw_cos,
    input  wire logic signed [15:0] i_yaw_sin,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [17:0]         o_score,
    output logic [10:0]         o_points_inside
);
    import gsm_pkg::*;

    logic [8:0]          r_map_width;
    logic [8:0]          r_map_height;
    logic [10:0]         r_num_points;
    logic signed [31:0]  r_origin_x;
    logic signed [31:0]  r_origin_y;
    logic [15:0]         r_cpm;
    logic signed [31:0]  r_sensor_x;
    logic signed [31:0]  r_sensor_y;

    t_state              r_state, n_state;
    logic [3:0]          r_step, n_step;
    logic [CNT_W-1:0]    r_idx, n_idx;

    logic signed [31:0]  r_pose_x, r_pose_y;
    logic signed [15:0]  r_cs, r_sn;
    logic signed [TW-1:0] r_offx, r_offy, r_tx, r_ty;
    logic [HW-1:0]       r_hi;
    logic [QW-1:0]       r_cx, r_cy;
    logic                r_negx, r_negy, r_hit;
    logic [17:0]         r_score;
    logic [10:0]         r_inside;

    logic                r_out_valid;
    logic [17:0]         r_out_score;
    logic [10:0]         r_out_inside;

    logic                cfg_wr;
    logic                in_acc;
    logic                out_free;
    logic [CNT_W-1:0]    n_eff;
    logic [CNT_W-1:0]    idx_inc;
    logic signed [32:0]  dx, dy;
    logic signed [TW-1:0] shx, shy;
    logic [TW-1:0]       magx, magy, mag;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod;
    logic [HW:0]         qsum;
    logic [QW-1:0]       q;
    logic [19:0]         idx_c;
    logic                hit_c;
    logic [18:0]         score_sum;
    logic                load_out;
    logic [7:0]          map_data;
    logic signed [31:0]  pt_x, pt_y;
    t_store_req          sreq;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 9'd256;
            r_map_height <= 9'd256;
            r_num_points <= 11'd0;
            r_origin_x   <= 32'sd0;
            r_origin_y   <= 32'sd0;
            r_cpm        <= 16'd5120;
            r_sensor_x   <= 32'sd0;
            r_sensor_y   <= 32'sd0;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[4:2]))
                REG_MAP_WIDTH:  r_map_width  <= pwdata[8:0];
                REG_MAP_HEIGHT: r_map_height <= pwdata[8:0];
                REG_NUM_POINTS: r_num_points <= pwdata[10:0];
                REG_ORIGIN_X:   r_origin_x   <= pwdata;
                REG_ORIGIN_Y:   r_origin_y   <= pwdata;
                REG_CPM:        r_cpm        <= pwdata[15:0];
                REG_SENSOR_X:   r_sensor_x   <= pwdata;
                REG_SENSOR_Y:   r_sensor_y   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[4:2]))
            REG_MAP_WIDTH:  prdata = {23'd0, r_map_width};
            REG_MAP_HEIGHT: prdata = {23'd0, r_map_height};
            REG_NUM_POINTS: prdata = {21'd0, r_num_points};
            REG_ORIGIN_X:   prdata = r_origin_x;
            REG_ORIGIN_Y:   prdata = r_origin_y;
            REG_CPM:        prdata = {16'd0, r_cpm};
            REG_SENSOR_X:   prdata = r_sensor_x;
            REG_SENSOR_Y:   prdata = r_sensor_y;
            default:        prdata = 32'd0;
        endcase
    end

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid & ~o_stall;
    assign out_free = ~r_out_valid | ~i_stall;

    assign n_eff = (32'(r_num_points) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                          : CNT_W'(r_num_points);
    assign idx_inc = r_idx + 1'b1;

    assign dx  = {r_pose_x[31], r_pose_x} - {r_origin_x[31], r_origin_x};
    assign dy  = {r_pose_y[31], r_pose_y} - {r_origin_y[31], r_origin_y};
    assign shx = {{(TW-47){dx[32]}}, dx, 14'd0};
    assign shy = {{(TW-47){dy[32]}}, dy, 14'd0};

    assign magx = r_tx[TW-1] ? TW'(-r_tx) : TW'(r_tx);
    assign magy = r_ty[TW-1] ? TW'(-r_ty) : TW'(r_ty);

    assign qsum = {1'b0, r_hi} + (HW+1)'(prod[HW-1:LO_W]);
    assign q    = qsum[QW+Q_SH-1:Q_SH];

    assign idx_c = 20'(prod[17:0]) + 20'(r_cx[8:0]);
    assign hit_c = ~r_negx & ~r_negy
                 & (r_cx < QW'(r_map_width)) & (r_cy < QW'(r_map_height))
                 & (32'(idx_c) < 32'(MAX_MAP_CELLS));

    assign score_sum = {1'b0, r_score} + 19'(map_data);
    assign load_out  = (r_state == S_DONE) & out_free;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        mul_a   = '0;
        mul_b   = '0;
        mag     = (r_step < 4'd6) ? magx : magy;
        sreq    = '0;
        sreq.map_wr      = in_acc & (i_operation == OP_MAP)
                         & (32'(i_address) < 32'(MAX_MAP_CELLS));
        sreq.map_wr_addr = MAP_AW'(i_address);
        sreq.map_wr_data = i_cell_value;
        sreq.pt_wr       = in_acc & (i_operation == OP_POINT)
                         & (32'(i_address) < 32'(MAX_POINTS));
        sreq.pt_wr_addr  = PT_AW'(i_address);
        sreq.pt_wr_x     = i_point_x;
        sreq.pt_wr_y     = i_point_y;
        sreq.map_rd_addr = MAP_AW'(idx_c);
        sreq.pt_rd_addr  = PT_AW'(r_idx);
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_operation == OP_SCORE) begin
                    n_state = S_OFF;
                    n_step  = 4'd0;
                    n_idx   = '0;
                end
            end
            S_OFF: begin
                case (r_step)
                    4'd0: begin mul_a = MA_W'(r_sensor_x); mul_b = MB_W'(r_cs); end
                    4'd1: begin mul_a = MA_W'(r_sensor_y); mul_b = MB_W'(r_sn); end
                    4'd2: begin mul_a = MA_W'(r_sensor_x); mul_b = MB_W'(r_sn); end
                    4'd3: begin mul_a = MA_W'(r_sensor_y); mul_b = MB_W'(r_cs); end
                    default: ;
                endcase
                n_step = r_step + 4'd1;
                if (r_step == 4'd4) begin
                    n_step = 4'd0;
                    if (n_eff == '0) begin
                        n_state = S_DONE;
                    end else begin
                        sreq.pt_rd = 1'b1;
                        n_state    = S_PT;
                    end
                end
            end
            S_PT: begin
                case (r_step)
                    4'd0: begin mul_a = MA_W'(pt_x); mul_b = MB_W'(r_cs); end
                    4'd1: begin mul_a = MA_W'(pt_y); mul_b = MB_W'(r_sn); end
                    4'd2: begin mul_a = MA_W'(pt_x); mul_b = MB_W'(r_sn); end
                    4'd3: begin mul_a = MA_W'(pt_y); mul_b = MB_W'(r_cs); end
                    4'd4, 4'd6: begin
                        mul_a = MA_W'({1'b0, mag[TW-1:LO_W]});
                        mul_b = MB_W'({1'b0, r_cpm});
                    end
                    4'd5, 4'd7: begin
                        mul_a = MA_W'({1'b0, mag[LO_W-1:0]});
                        mul_b = MB_W'({1'b0, r_cpm});
                    end
                    4'd9: begin
                        mul_a = MA_W'({1'b0, r_cy[8:0]});
                        mul_b = MB_W'({1'b0, r_map_width});
                    end
                    4'd10: begin
                        sreq.map_rd = 1'b1;
                    end
                    default: ;
                endcase
                n_step = r_step + 4'd1;
                if (r_step == 4'd11) begin
                    n_step = 4'd0;
                    n_idx  = idx_inc;
                    if (idx_inc < n_eff) begin
                        sreq.pt_rd      = 1'b1;
                        sreq.pt_rd_addr = PT_AW'(idx_inc);
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 4'd0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_SCORE) begin
            r_pose_x <= i_pose_x;
            r_pose_y <= i_pose_y;
            r_cs     <= i_yaw_cos;
            r_sn     <= i_yaw_sin;
            r_score  <= 18'd0;
            r_inside <= 11'd0;
        end
        if (r_state == S_OFF) begin
            case (r_step)
                4'd1: r_offx <= prod[TW-1:0] + shx;
                4'd2: r_offx <= r_offx - prod[TW-1:0];
                4'd3: r_offy <= prod[TW-1:0] + shy;
                4'd4: r_offy <= r_offy + prod[TW-1:0];
                default: ;
            endcase
        end
        if (r_state == S_PT) begin
            case (r_step)
                4'd1: r_tx <= prod[TW-1:0] + r_offx;
                4'd2: r_tx <= r_tx - prod[TW-1:0];
                4'd3: r_ty <= prod[TW-1:0] + r_offy;
                4'd4: r_ty <= r_ty + prod[TW-1:0];
                4'd5, 4'd7: r_hi <= prod[HW-1:0];
                4'd6: begin
                    r_cx   <= q;
                    r_negx <= r_tx[TW-1] & (q != '0);
                end
                4'd8: begin
                    r_cy   <= q;
                    r_negy <= r_ty[TW-1] & (q != '0);
                end
                4'd10: r_hit <= hit_c;
                4'd11: begin
                    if (r_hit) begin
                        r_score <= score_sum[18] ? SCORE_MAX : score_sum[17:0];
                        if (r_inside != INSIDE_MAX) begin
                            r_inside <= r_inside + 11'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_score  <= r_score;
            r_out_inside <= r_inside;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_score         = r_out_score;
    assign o_points_inside = r_out_inside;

    gsm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    gsm_store u_store (
        .i_clk      (i_clk),
        .i_req      (sreq),
        .o_map_data (map_data),
        .o_pt_x     (pt_x),
        .o_pt_y     (pt_y)
    );
endmodule
`default_nettype wire

// ===== design/gsm_mul.sv =====
`default_nettype none
module gsm_mul (
    input  wire logic                               i_clk,
    input  wire logic signed [gsm_pkg::MA_W-1:0]    i_a,
    input  wire logic signed [gsm_pkg::MB_W-1:0]    i_b,
    output logic signed [gsm_pkg::MP_W-1:0]         o_prod
);
    import gsm_pkg::*;

    logic signed [MP_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

// ===== design/gsm_store.sv =====
`default_nettype none
module gsm_store (
    input  wire logic                  i_clk,
    input  wire gsm_pkg::t_store_req   i_req,
    output logic [7:0]                 o_map_data,
    output logic signed [31:0]         o_pt_x,
    output logic signed [31:0]         o_pt_y
);
    import gsm_pkg::*;

    logic [7:0]  r_map [MAX_MAP_CELLS];
    logic [63:0] r_pts [MAX_POINTS];
    logic [7:0]  r_map_data;
    logic [63:0] r_pt_data;

    always_ff @(posedge i_clk) begin
        if (i_req.map_wr) begin
            r_map[i_req.map_wr_addr] <= i_req.map_wr_data;
        end
        if (i_req.map_rd) begin
            r_map_data <= r_map[i_req.map_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.pt_wr) begin
            r_pts[i_req.pt_wr_addr] <= {i_req.pt_wr_y, i_req.pt_wr_x};
        end
        if (i_req.pt_rd) begin
            r_pt_data <= r_pts[i_req.pt_rd_addr];
        end
    end

    assign o_map_data = r_map_data;
    assign o_pt_x = r_pt_data[31:0];
    assign o_pt_y = r_pt_data[63:32];
endmodule
`default_nettype wire

// ===== design/gsm_chk.sv =====
`default_nettype none
module gsm_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [17:0] o_score,
    input  wire logic [10:0] o_points_inside
);
    import gsm_pkg::*;

    a_reset_drop: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("word valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_score) && $stable(o_points_inside))
        else $error("stalled result word changed");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_points_inside == 11'd0 |-> o_score == 18'd0)
        else $error("score without hits");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_operation == OP_SCORE |=> o_stall)
        else $error("query did not start");

    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without query");
endmodule

bind grid_scan_match_pose_score_top gsm_chk u_gsm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_operation     (i_operation),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_score         (o_score),
    .o_points_inside (o_points_inside)
);
`default_nettype wire
